// ===== src/assert_macros.svh =====
// Assertion macros used by perpendicular_unit_vector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/pvu_pkg.sv =====
// ----------------------------------------------------------------------------
// pvu_pkg
// Types, widths and helpers for the perpendicular unit vector pipeline.
// ----------------------------------------------------------------------------
package pvu_pkg;

    localparam int FRAC_BITS = 14;
    localparam int Q_STEPS   = 2 * FRAC_BITS;      // fraction bits of the quotient
    localparam int QW        = Q_STEPS + 1;        // quotient width (value <= 2^Q_STEPS)
    localparam int RTW       = (QW + 1) / 2;       // root width
    localparam int AW        = 17;                 // magnitude of a 16-bit component
    localparam int NW        = 32;                 // squares, N, S, products
    localparam int DW        = 64;                 // products of two NW values
    localparam int RW        = DW + 1;             // divider remainder
    localparam int FRONT_LAT = 4;
    localparam int TAIL_LAT  = QW + RTW;
    localparam int LATENCY   = FRONT_LAT + TAIL_LAT + 1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
    } pvu_in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [1:0]         chosen_axis;
        logic               zero_input;
    } pvu_out_t;

    // sideband that travels beside the arithmetic
    typedef struct packed {
        logic       valid;
        logic [1:0] axis;
        logic       zero;
        logic [2:0] neg;
    } pvu_side_t;

    // apply sign to a magnitude and clip to 16-bit signed
    function automatic logic [15:0] pvu_pack(input logic [RTW-1:0] mag, input logic neg);
        logic [31:0] m;
        m = 32'(mag);
        if (neg)
            pvu_pack = (m > 32'd32768) ? 16'h8000 : 16'(-m);
        else
            pvu_pack = (m > 32'd32767) ? 16'h7fff : m[15:0];
    endfunction

endpackage

// ===== src/pvu_front.sv =====
// ----------------------------------------------------------------------------
// pvu_front
// Axis pick, squares, products and the dividend / divisor of each lane.
// ----------------------------------------------------------------------------
module pvu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  pvu_pkg::pvu_in_t in_word,
    output logic [pvu_pkg::DW-1:0] num [3],
    output logic [pvu_pkg::DW-1:0] den [3],
    output pvu_pkg::pvu_side_t     side
);
    import pvu_pkg::*;

    logic [AW-1:0] a_c [3];
    logic [2:0]    s_c;
    logic [1:0]    p_c;
    logic [AW-1:0] best_c;

    logic [AW-1:0] a_reg [3];
    logic [NW-1:0] sq_reg [3];
    logic [NW-1:0] pr_reg [3];
    logic [NW-1:0] n_reg, s_reg;
    logic [DW-1:0] p2_reg [3];
    logic [DW-1:0] ns_reg;
    logic [NW-1:0] n3_reg, s3_reg;
    logic [DW-1:0] p23_reg [3];
    logic [1:0]    p1_reg;
    logic [1:0]    p2a_reg;
    pvu_side_t     sd_reg [FRONT_LAT];
    pvu_side_t     sd_next;

    // magnitudes and axis pick
    always_comb
    begin
        a_c[0] = in_word.in_x[15] ? AW'(-(AW'(in_word.in_x))) : AW'(in_word.in_x);
        a_c[1] = in_word.in_y[15] ? AW'(-(AW'(in_word.in_y))) : AW'(in_word.in_y);
        a_c[2] = in_word.in_z[15] ? AW'(-(AW'(in_word.in_z))) : AW'(in_word.in_z);
        s_c    = {in_word.in_z[15], in_word.in_y[15], in_word.in_x[15]};
        p_c    = AXIS_X;
        best_c = '1;
        for (int i = 0; i < 3; i++)
        begin
            if ((32'(a_c[i]) < (32'd1 << FRAC_BITS)) && (best_c == '1 || a_c[i] < best_c))
            begin
                best_c = a_c[i];
                p_c    = 2'(i);
            end
        end
        sd_next.valid = in_valid;
        sd_next.axis  = (a_c[0] == '0 && a_c[1] == '0 && a_c[2] == '0) ? AXIS_X : p_c;
        sd_next.zero  = (a_c[0] == '0 && a_c[1] == '0 && a_c[2] == '0);
        for (int i = 0; i < 3; i++)
            sd_next.neg[i] = (2'(i) != p_c) && (s_c[i] == s_c[p_c]);
    end

    // sideband delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRONT_LAT; k++)
                sd_reg[k] <= '0;
        end
        else
        begin
            sd_reg[0] <= sd_next;
            for (int k = 1; k < FRONT_LAT; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        // stage 0
        for (int i = 0; i < 3; i++)
            a_reg[i] <= a_c[i];
        p1_reg <= p_c;
        // stage 1: squares and products with the chosen component
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= NW'(a_reg[i]) * NW'(a_reg[i]);
            pr_reg[i] <= NW'(a_reg[i]) * NW'(a_reg[p1_reg]);
        end
        p2a_reg <= p1_reg;
        // stage 2: N, S, squared products
        n_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        s_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] - sq_reg[p2a_reg];
        for (int i = 0; i < 3; i++)
            p2_reg[i] <= pr_reg[i] * pr_reg[i];
        // stage 3: N * S
        ns_reg <= n_reg * s_reg;
        n3_reg <= n_reg;
        s3_reg <= s_reg;
        for (int i = 0; i < 3; i++)
            p23_reg[i] <= p2_reg[i];
    end

    // lane operands
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (sd_reg[FRONT_LAT-1].axis == 2'(i))
            begin
                num[i] = DW'(s3_reg);
                den[i] = DW'(n3_reg);
            end
            else
            begin
                num[i] = p23_reg[i];
                den[i] = ns_reg;
            end
        end
    end

    assign side = sd_reg[FRONT_LAT-1];

endmodule

// ===== src/pvu_div.sv =====
// ----------------------------------------------------------------------------
// pvu_div
// Pipelined restoring divider: floor(num * 2^Q_STEPS / den), one bit a stage.
// ----------------------------------------------------------------------------
module pvu_div (
    input  logic                    clk,
    input  logic [pvu_pkg::DW-1:0]  num,
    input  logic [pvu_pkg::DW-1:0]  den,
    output logic [pvu_pkg::QW-1:0]  quo
);
    import pvu_pkg::*;

    logic [RW-1:0] r_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [RW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        if (k == 0)
        begin : g_first
            assign r_in = RW'(num);
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign r_in = {r_reg[k-1][RW-2:0], 1'b0};
            assign d_in = d_reg[k-1];
            assign q_in = {q_reg[k-1][QW-2:0], 1'b0};
        end
        always_ff @(posedge clk)
        begin
            d_reg[k] <= d_in;
            if (r_in >= RW'(d_in))
            begin
                r_reg[k] <= r_in - RW'(d_in);
                q_reg[k] <= q_in | QW'(1);
            end
            else
            begin
                r_reg[k] <= r_in;
                q_reg[k] <= q_in;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ===== src/pvu_sqrt.sv =====
// ----------------------------------------------------------------------------
// pvu_sqrt
// Pipelined integer square root, one root bit a stage.
// ----------------------------------------------------------------------------
module pvu_sqrt (
    input  logic                     clk,
    input  logic [pvu_pkg::QW-1:0]   val,
    output logic [pvu_pkg::RTW-1:0]  root
);
    import pvu_pkg::*;

    localparam int VW = 2 * RTW;
    localparam int MW = RTW + 2;

    logic [VW-1:0]  v_reg [RTW];
    logic [MW-1:0]  m_reg [RTW];
    logic [RTW-1:0] t_reg [RTW];

    for (genvar k = 0; k < RTW; k++)
    begin : g_stage
        logic [VW-1:0]  v_in;
        logic [MW-1:0]  m_in;
        logic [RTW-1:0] t_in;
        logic [MW-1:0]  rem;
        logic [MW-1:0]  trial;
        if (k == 0)
        begin : g_first
            assign v_in = VW'(val);
            assign m_in = '0;
            assign t_in = '0;
        end
        else
        begin : g_next
            assign v_in = v_reg[k-1];
            assign m_in = m_reg[k-1];
            assign t_in = t_reg[k-1];
        end
        // bring down the next two bits, try root bit one
        assign rem   = {m_in[MW-3:0], v_in[VW-1:VW-2]};
        assign trial = {t_in, 2'b01};
        always_ff @(posedge clk)
        begin
            v_reg[k] <= {v_in[VW-3:0], 2'b00};
            if (rem >= trial)
            begin
                m_reg[k] <= rem - trial;
                t_reg[k] <= {t_in[RTW-2:0], 1'b1};
            end
            else
            begin
                m_reg[k] <= rem;
                t_reg[k] <= {t_in[RTW-2:0], 1'b0};
            end
        end
    end

    assign root = t_reg[RTW-1];

endmodule

// ===== src/perpendicular_unit_vector.sv =====
// ----------------------------------------------------------------------------
// perpendicular_unit_vector
// Unit vector perpendicular to a Q1.14 3-vector, fully pipelined.
// ----------------------------------------------------------------------------
// A word is taken in every cycle that start is high (busy is always low) and
// its result appears on result with done high after passing 4 front stages,
// 29 divider stages, 15 square root stages and one output register. The
// pipeline length is set by the bit-per-stage divider and root pipes.
// Results cannot be held off; each lasts one cycle.
module perpendicular_unit_vector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pvu_pkg::pvu_in_t  in_word,
    output logic              done,
    output pvu_pkg::pvu_out_t result
);
    import pvu_pkg::*;
    `include "assert_macros.svh"

    logic [DW-1:0]  num [3];
    logic [DW-1:0]  den [3];
    logic [QW-1:0]  quo [3];
    logic [RTW-1:0] mag [3];
    pvu_side_t      side;
    pvu_side_t      sd_reg [TAIL_LAT];
    pvu_side_t      st;
    pvu_out_t       result_reg;
    pvu_out_t       result_next;
    logic           done_reg;

    assign busy = 1'b0;

    pvu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_word  (in_word),
        .num      (num),
        .den      (den),
        .side     (side)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        pvu_div u_div (
            .clk (clk),
            .num (num[i]),
            .den (den[i]),
            .quo (quo[i])
        );
        pvu_sqrt u_sqrt (
            .clk  (clk),
            .val  (quo[i]),
            .root (mag[i])
        );
    end

    // sideband delay across divider and root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAIL_LAT; k++)
                sd_reg[k] <= '0;
        end
        else
        begin
            sd_reg[0] <= side;
            for (int k = 1; k < TAIL_LAT; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    assign st = sd_reg[TAIL_LAT-1];

    // sign, clip, zero-input override
    always_comb
    begin
        result_next.out_x       = st.zero ? '0 : pvu_pack(mag[0], st.neg[0]);
        result_next.out_y       = st.zero ? '0 : pvu_pack(mag[1], st.neg[1]);
        result_next.out_z       = st.zero ? '0 : pvu_pack(mag[2], st.neg[2]);
        result_next.chosen_axis = st.axis;
        result_next.zero_input  = st.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= st.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMPLY(a_zero_out, clk, rst_n, done && result.zero_input,
        result.out_x == 16'sd0 && result.out_y == 16'sd0 && result.out_z == 16'sd0)
    `ASSERT_IMPLY(a_axis_ok, clk, rst_n, done,
        result.chosen_axis == AXIS_X || result.chosen_axis == AXIS_Y ||
        result.chosen_axis == AXIS_Z)
    `ASSERT_IMPLY(a_axis_pos, clk, rst_n, done,
        !((result.chosen_axis == AXIS_X && result.out_x[15]) ||
          (result.chosen_axis == AXIS_Y && result.out_y[15]) ||
          (result.chosen_axis == AXIS_Z && result.out_z[15])))
    `ASSERT_NEXT(a_tail_done, clk, rst_n, st.valid, done)

endmodule
